// ----- design/scfla_pkg.sv -----
// shared types and constants for the size class free list allocator
`timescale 1ns / 1ps

package scfla_pkg;

   // number of size classes and field widths
   localparam int CLASS_COUNT          = 4;
   localparam int CLASS_W              = 2;
   localparam int LIMIT_W              = 16;
   localparam int FIELD_INDEX_W        = 8;
   localparam int STATUS_W             = 2;
   localparam int CSR_INDEX_W          = 2;
   localparam int BLOCKS_PER_CLASS_DEF = 256;

   // reset values of the class limit registers
   localparam logic [LIMIT_W-1:0] LIMIT_RESET [CLASS_COUNT] =
      '{16'd16, 16'd32, 16'd64, 16'd128};

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LIMIT_ZERO  = 2'd0,
      REG_LIMIT_ONE   = 2'd1,
      REG_LIMIT_TWO   = 2'd2,
      REG_LIMIT_THREE = 2'd3
   } reg_index_type;

   // request operation codes
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clr_step;
      logic alloc_start;
      logic alloc_finish;
      logic free_do;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clr_last;
      logic out_busy;
   } dp_stat_type;

endpackage

// ----- design/scfla_req_if.sv -----
// request channel interface
`timescale 1ns / 1ps

interface scfla_req_if import scfla_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [LIMIT_W-1:0]       request_size;
   logic [CLASS_W-1:0]       free_class;
   logic [FIELD_INDEX_W-1:0] free_index;

   modport source (output valid, cmd, request_size, free_class, free_index, input ready);
   modport sink   (input valid, cmd, request_size, free_class, free_index, output ready);
endinterface

// ----- design/scfla_rsp_if.sv -----
// response channel interface
`timescale 1ns / 1ps

interface scfla_rsp_if import scfla_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [CLASS_W-1:0]       granted_class;
   logic [FIELD_INDEX_W-1:0] granted_index;

   modport source (output valid, status, granted_class, granted_index, input ready);
   modport sink   (input valid, status, granted_class, granted_index, output ready);
endinterface

// ----- design/scfla_ctrl.sv -----
// controller state machine: link store initialisation and request sequencing
`timescale 1ns / 1ps

module scfla_ctrl import scfla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_cmd,
   output logic        req_ready,
   input  dp_stat_type dp_stat,
   output ctl_cmd_type ctl_cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      ctl_cmd   = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl_cmd.clr_step = 1'b1;
            if (dp_stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = !dp_stat.out_busy;
            if (req_valid && !dp_stat.out_busy) begin
               if (req_cmd == CMD_FREE) begin
                  ctl_cmd.free_do = 1'b1;
               end else begin
                  ctl_cmd.alloc_start = 1'b1;
                  state_in            = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            ctl_cmd.alloc_finish = 1'b1;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/scfla_dpath.sv -----
// datapath: limit registers, class heads, next-link store and response register
`timescale 1ns / 1ps

module scfla_dpath import scfla_pkg::*; #(
   parameter int unsigned BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [LIMIT_W-1:0]       csr_wdata,
   input  ctl_cmd_type              ctl_cmd,
   output dp_stat_type              dp_stat,
   input  logic [LIMIT_W-1:0]       req_size,
   input  logic [CLASS_W-1:0]       req_free_class,
   input  logic [FIELD_INDEX_W-1:0] req_free_index,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [CLASS_W-1:0]       rsp_granted_class,
   output logic [FIELD_INDEX_W-1:0] rsp_granted_index
);

   localparam int unsigned IDX_W  = $clog2(BLOCKS_PER_CLASS);
   localparam int unsigned LINK_W = $clog2(BLOCKS_PER_CLASS + 1);
   localparam int unsigned ADDR_W = CLASS_W + IDX_W;
   localparam int unsigned DEPTH  = 2 ** ADDR_W;
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(BLOCKS_PER_CLASS);

   logic [LIMIT_W-1:0]       limit_ff [CLASS_COUNT];
   logic [LINK_W-1:0]        head_ff  [CLASS_COUNT];
   logic [LINK_W-1:0]        link_mem [DEPTH];
   logic [ADDR_W-1:0]        clr_cnt_ff;
   logic [IDX_W-1:0]         clr_idx;
   logic [IDX_W:0]           clr_link_wide;
   logic                     sel_found;
   logic [CLASS_W-1:0]       sel_class;
   logic [CLASS_W-1:0]       head_rd_class;
   logic [LINK_W-1:0]        head_rd;
   logic [31:0]              fidx_wide;
   logic                     free_in_range;
   logic                     mem_wr_en;
   logic [ADDR_W-1:0]        mem_wr_addr;
   logic [LINK_W-1:0]        mem_wr_data;
   logic [ADDR_W-1:0]        mem_rd_addr;
   logic [CLASS_W-1:0]       cls_ff;
   logic                     found_ff;
   logic [LINK_W-1:0]        head_q_ff;
   logic [LINK_W-1:0]        rd_data_ff;
   logic                     head_empty;
   logic [31:0]              gidx_wide;
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [CLASS_W-1:0]       rsp_class_ff;
   logic [FIELD_INDEX_W-1:0] rsp_index_ff;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            limit_ff[i] <= LIMIT_RESET[i];
         end
      end else if (csr_wr_en) begin
         limit_ff[csr_index] <= csr_wdata;
      end
   end

   // first class whose limit covers the request
   always_comb begin
      sel_found = 1'b0;
      sel_class = '0;
      for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
         if (req_size <= limit_ff[i]) begin
            sel_found = 1'b1;
            sel_class = CLASS_W'(i);
         end
      end
   end

   // head read, free index range check
   assign head_rd_class = ctl_cmd.free_do ? req_free_class : sel_class;
   assign head_rd       = head_ff[head_rd_class];
   assign fidx_wide     = 32'(req_free_index);
   assign free_in_range = fidx_wide < 32'(BLOCKS_PER_CLASS);

   // link store write port: initialisation sweep or push on free
   assign clr_idx       = clr_cnt_ff[IDX_W-1:0];
   assign clr_link_wide = {1'b0, clr_idx} + (IDX_W + 1)'(1);
   assign mem_wr_en     = ctl_cmd.clr_step || (ctl_cmd.free_do && free_in_range);
   assign mem_wr_addr   = ctl_cmd.clr_step ? clr_cnt_ff
                                           : {req_free_class, fidx_wide[IDX_W-1:0]};
   assign mem_wr_data   = ctl_cmd.clr_step ? LINK_W'(clr_link_wide) : head_rd;
   assign mem_rd_addr   = {sel_class, head_rd[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   // registered read of the next link of the chosen head
   always_ff @(posedge clock) begin
      if (ctl_cmd.alloc_start) begin
         rd_data_ff <= link_mem[mem_rd_addr];
      end
   end

   // initialisation sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl_cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // allocate lookup context
   always_ff @(posedge clock) begin
      if (ctl_cmd.alloc_start) begin
         cls_ff    <= sel_class;
         found_ff  <= sel_found;
         head_q_ff <= head_rd;
      end
   end

   assign head_empty = head_q_ff >= END_MARK;

   // class heads: push on free, pop on granted allocate
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            head_ff[i] <= '0;
         end
      end else if (ctl_cmd.free_do && free_in_range) begin
         head_ff[req_free_class] <= fidx_wide[LINK_W-1:0];
      end else if (ctl_cmd.alloc_finish && found_ff && !head_empty) begin
         head_ff[cls_ff] <= rd_data_ff;
      end
   end

   // response register
   assign gidx_wide = 32'(head_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.free_do || ctl_cmd.alloc_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.free_do) begin
         rsp_status_ff <= STATUS_DONE;
         rsp_class_ff  <= '0;
         rsp_index_ff  <= '0;
      end else if (ctl_cmd.alloc_finish) begin
         if (!found_ff) begin
            rsp_status_ff <= STATUS_TOO_LARGE;
            rsp_class_ff  <= '0;
            rsp_index_ff  <= '0;
         end else if (head_empty) begin
            rsp_status_ff <= STATUS_EMPTY;
            rsp_class_ff  <= '0;
            rsp_index_ff  <= '0;
         end else begin
            rsp_status_ff <= STATUS_DONE;
            rsp_class_ff  <= cls_ff;
            rsp_index_ff  <= gidx_wide[FIELD_INDEX_W-1:0];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_class = rsp_class_ff;
   assign rsp_granted_index = rsp_index_ff;

   // status to controller
   assign dp_stat.clr_last = &clr_cnt_ff;
   assign dp_stat.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

// ----- design/size_class_free_list_allocator.sv -----
// Four-class free list block allocator. Each class keeps its free blocks as a stack: a head
// register per class and one next-link entry per block in a link store. An allocate transfer
// picks the first class, zero to three, whose limit register covers the request size, pops that
// class's head and returns class and index; it answers too large or class empty when it cannot.
// A free transfer pushes the given block back on its class if its index is below
// BLOCKS_PER_CLASS, with no double free check. Items are handled one at a time; an allocate
// waits in a lookup state on the registered read of the link store. A new request is taken once
// the previous response has been taken or is taken in the same cycle. After reset the link
// store is initialised by a sweep over its 4 * 2**clog2(BLOCKS_PER_CLASS) entries (1024 at the
// default), during which no request is taken; csr writes are accepted throughout.
`timescale 1ns / 1ps

module size_class_free_list_allocator import scfla_pkg::*; #(
   parameter int unsigned BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   scfla_req_if.sink              req_chan,
   scfla_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata
);

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   // sequencing
   scfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   // storage and response
   scfla_dpath #(
      .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .ctl_cmd           (ctl_cmd),
      .dp_stat           (dp_stat),
      .req_size          (req_chan.request_size),
      .req_free_class    (req_chan.free_class),
      .req_free_index    (req_chan.free_index),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_granted_class (rsp_chan.granted_class),
      .rsp_granted_index (rsp_chan.granted_index)
   );

endmodule

// ----- design/scfla_checker.sv -----
// port-level checks for the allocator and their binding to the top level
`timescale 1ns / 1ps

module scfla_checker import scfla_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_cmd,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [CLASS_W-1:0]       rsp_granted_class,
   input logic [FIELD_INDEX_W-1:0] rsp_granted_index
);

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // no request transfer while a response is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("request taken over a stalled response");

   // a free answers in the next cycle with done and no grant
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_FREE |=>
         rsp_valid && rsp_status == STATUS_DONE &&
         rsp_granted_class == '0 && rsp_granted_index == '0)
      else $error("free response wrong");

   // an allocate is answered only after its lookup state, with no response offered in between
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_ALLOC |=> !rsp_valid ##1 rsp_valid)
      else $error("allocate response timing wrong");

   // a refused allocate carries no grant
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |->
         rsp_granted_class == '0 && rsp_granted_index == '0)
      else $error("grant fields set on refusal");

endmodule

bind size_class_free_list_allocator scfla_checker u_scfla_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_cmd           (req_chan.cmd),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_granted_class (rsp_chan.granted_class),
   .rsp_granted_index (rsp_chan.granted_index)
);

// ----- sim/tb_top.sv -----
// testbench for the size class free list allocator: directed and random transfers against a predictor
`timescale 1ns / 1ps

module tb_top;
   import scfla_pkg::*;

   // no-transfer limit for the watchdog, well above the link store sweep
   localparam int QUIET_LIMIT = 4000;
   localparam logic [8:0] LIST_END = 9'd256;
   localparam int PHASES = 5;

   typedef struct packed {
      status_type               st;
      logic [CLASS_W-1:0]       gc;
      logic [FIELD_INDEX_W-1:0] gi;
   } grant_type;

   typedef struct packed {
      logic [CLASS_W-1:0]       c;
      logic [FIELD_INDEX_W-1:0] i;
   } block_ref_type;

   typedef struct {
      cmd_type                  op;
      logic [LIMIT_W-1:0]       size;
      logic [CLASS_W-1:0]       fc;
      logic [FIELD_INDEX_W-1:0] fi;
      bit                       typed;
      status_type               st;
      logic [CLASS_W-1:0]       gc;
      logic [FIELD_INDEX_W-1:0] gi;
   } opening_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]     csr_wdata;

   scfla_req_if req_bus ();
   scfla_rsp_if rsp_bus ();

   size_class_free_list_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state: limits, stack heads and next links per class
   logic [LIMIT_W-1:0] class_limits [CLASS_COUNT];
   logic [8:0]         free_heads [CLASS_COUNT];
   logic [8:0]         free_links [CLASS_COUNT][256];
   block_ref_type      live_blocks [$];
   grant_type          pending_grants [$];

   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int status_seen [3] = '{0, 0, 0};
   int quiet_cycles = 0;
   int drv_calm = 0;
   int rdy_calm = 0;
   grant_type want;

   // opening transfers; limits still at their reset values
   opening_row_type opening_rows [21] = '{
      '{CMD_ALLOC, 16'd0,     2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd16,    2'd3, 8'd255, 1'b1, STATUS_DONE,      2'd0, 8'd1},
      '{CMD_ALLOC, 16'd17,    2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd1, 8'd0},
      '{CMD_ALLOC, 16'd32,    2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd1, 8'd1},
      '{CMD_ALLOC, 16'd33,    2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd2, 8'd0},
      '{CMD_ALLOC, 16'd64,    2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd2, 8'd1},
      '{CMD_ALLOC, 16'd65,    2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd3, 8'd0},
      '{CMD_ALLOC, 16'd128,   2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd3, 8'd1},
      '{CMD_ALLOC, 16'd129,   2'd0, 8'd0,   1'b1, STATUS_TOO_LARGE, 2'd0, 8'd0},
      '{CMD_ALLOC, 16'd65535, 2'd3, 8'd255, 1'b1, STATUS_TOO_LARGE, 2'd0, 8'd0},
      '{CMD_FREE,  16'd65535, 2'd3, 8'd255, 1'b1, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd128,   2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd3, 8'd255},
      '{CMD_ALLOC, 16'd100,   2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd3, 8'd2},
      '{CMD_FREE,  16'd0,     2'd2, 8'd0,   1'b1, STATUS_DONE,      2'd0, 8'd0},
      // double free of the same block
      '{CMD_FREE,  16'd0,     2'd2, 8'd0,   1'b1, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd40,    2'd0, 8'd0,   1'b0, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd40,    2'd0, 8'd0,   1'b0, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_FREE,  16'd0,     2'd1, 8'd128, 1'b1, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd20,    2'd0, 8'd0,   1'b0, STATUS_DONE,      2'd0, 8'd0},
      '{CMD_ALLOC, 16'd1,     2'd0, 8'd0,   1'b1, STATUS_DONE,      2'd0, 8'd2},
      '{CMD_FREE,  16'hAAAA,  2'd0, 8'd1,   1'b1, STATUS_DONE,      2'd0, 8'd0}
   };

   // limit settings per phase, with the share of allocates and of stray frees
   logic [LIMIT_W-1:0] phase_limits [PHASES][CLASS_COUNT] = '{
      '{16'd16,    16'd32,    16'd64,    16'd128},
      '{16'd65535, 16'd0,     16'd0,     16'd0},
      '{16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd300,   16'd100,   16'd65535, 16'd5},
      '{16'd65535, 16'd65535, 16'd65535, 16'd65535}
   };
   int phase_items [PHASES] = '{200, 380, 100, 250, 220};
   int phase_alloc_pct [PHASES] = '{60, 92, 70, 75, 50};
   int phase_noise_pct [PHASES] = '{15, 0, 20, 15, 25};

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // gap length: mostly none or short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm == 0 && $urandom_range(0, 63) == 0) calm = $urandom_range(20, 60);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // predictor reset: every stack runs 0 .. 255 then the end mark
   function automatic void clear_lists();
      for (int c = 0; c < CLASS_COUNT; c++) begin
         class_limits[c] = LIMIT_RESET[c];
         free_heads[c] = 9'd0;
         for (int i = 0; i < 256; i++) free_links[c][i] = 9'(i + 1);
      end
   endfunction

   // one transfer through the predictor: pop or push on a class stack
   function automatic grant_type predict_grant(cmd_type op, logic [LIMIT_W-1:0] size,
                                               logic [CLASS_W-1:0] fc,
                                               logic [FIELD_INDEX_W-1:0] fi);
      grant_type     r;
      int            c;
      bit            hit;
      block_ref_type b;
      r = '{STATUS_DONE, 2'd0, 8'd0};
      if (op == CMD_FREE) begin
         // an 8 bit index is always inside the class
         free_links[fc][fi] = free_heads[fc];
         free_heads[fc] = {1'b0, fi};
      end else begin
         hit = 1'b0;
         c = 0;
         for (int k = 0; k < CLASS_COUNT; k++) begin
            if (!hit && size <= class_limits[k]) begin
               hit = 1'b1;
               c = k;
            end
         end
         if (!hit) begin
            r.st = STATUS_TOO_LARGE;
         end else if (free_heads[c] >= LIST_END) begin
            r.st = STATUS_EMPTY;
         end else begin
            r.gc = c[CLASS_W-1:0];
            r.gi = free_heads[c][7:0];
            free_heads[c] = free_links[c][free_heads[c][7:0]];
            b.c = r.gc;
            b.i = r.gi;
            live_blocks.push_back(b);
         end
      end
      return r;
   endfunction

   // present one request, wait for its transfer, then queue the expected response
   task automatic send_request(cmd_type op, logic [LIMIT_W-1:0] size,
                               logic [CLASS_W-1:0] fc, logic [FIELD_INDEX_W-1:0] fi,
                               bit typed, grant_type typed_val);
      int        gap;
      grant_type r;
      gap = pick_gap(drv_calm);
      if (gap > 0) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= op;
      req_bus.request_size <= size;
      req_bus.free_class   <= fc;
      req_bus.free_index   <= fi;
      do @(posedge clock); while (!req_bus.ready);
      r = predict_grant(op, size, fc, fi);
      if (typed) r = typed_val;
      status_seen[r.st]++;
      pending_grants.push_back(r);
      sent_count++;
   endtask

   // random request: allocates of sizes at and around the limits, or frees mostly of live blocks
   task automatic random_request(int alloc_pct, int noise_pct);
      cmd_type                  op;
      logic [LIMIT_W-1:0]       size;
      logic [LIMIT_W-1:0]       lim;
      logic [CLASS_W-1:0]       fc;
      logic [FIELD_INDEX_W-1:0] fi;
      int                       k;
      size = 16'($urandom_range(0, 65535));
      fc = 2'($urandom_range(0, 3));
      fi = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < alloc_pct) begin
         op = CMD_ALLOC;
         lim = class_limits[$urandom_range(0, 3)];
         case ($urandom_range(0, 5))
            0: size = lim;
            1: size = lim + 16'd1;
            2: size = 16'd0;
            3: size = 16'hFFFF;
            4: size = 16'($urandom_range(0, lim));
            default: ;
         endcase
      end else begin
         op = CMD_FREE;
         if (live_blocks.size() != 0 && $urandom_range(0, 99) >= noise_pct) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            fc = live_blocks[k].c;
            fi = live_blocks[k].i;
            live_blocks.delete(k);
         end
      end
      send_request(op, size, fc, fi, 1'b0, '0);
   endtask

   // let every outstanding response arrive before touching the limits
   task automatic wait_quiet();
      @(negedge clock) req_bus.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all four limit registers back to back
   task automatic set_limits(int p);
      for (int k = 0; k < CLASS_COUNT; k++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= reg_index_type'(k);
         csr_wdata <= phase_limits[p][k];
         class_limits[k] = phase_limits[p][k];
      end
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   // response side ready with random stalls
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         gap = pick_gap(rdy_calm);
         if (gap > 0) begin
            @(negedge clock) rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock) rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         checked_count++;
         if (pending_grants.size() == 0) begin
            $display("%0t: response with nothing expected: status %0d class %0d index %0d",
                     $time, rsp_bus.status, rsp_bus.granted_class, rsp_bus.granted_index);
            mismatch_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.status !== want.st) begin
               $display("%0t: status expected %0d got %0d", $time, want.st, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.granted_class !== want.gc) begin
               $display("%0t: granted_class expected %0d got %0d",
                        $time, want.gc, rsp_bus.granted_class);
               mismatch_count++;
            end
            if (rsp_bus.granted_index !== want.gi) begin
               $display("%0t: granted_index expected %0d got %0d",
                        $time, want.gi, rsp_bus.granted_index);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: no transfer for %0d cycles", quiet_cycles);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      grant_type row_grant;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_ALLOC;
      req_bus.request_size = '0;
      req_bus.free_class   = '0;
      req_bus.free_index   = '0;
      csr_wr_en            = 1'b0;
      csr_index            = REG_LIMIT_ZERO;
      csr_wdata            = '0;
      reset                = 1'b1;
      clear_lists();
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed opening rows
      foreach (opening_rows[n]) begin
         row_grant.st = opening_rows[n].st;
         row_grant.gc = opening_rows[n].gc;
         row_grant.gi = opening_rows[n].gi;
         send_request(opening_rows[n].op, opening_rows[n].size, opening_rows[n].fc,
                      opening_rows[n].fi, opening_rows[n].typed, row_grant);
      end

      // random phases, each under its own limit setting
      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         set_limits(p);
         repeat (phase_items[p]) random_request(phase_alloc_pct[p], phase_noise_pct[p]);
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      $display("tb_top: %0d requests sent, %0d responses checked over %0d limit settings",
               sent_count, checked_count, PHASES);
      $display("tb_top: %0d granted or freed, %0d too large, %0d class empty",
               status_seen[STATUS_DONE], status_seen[STATUS_TOO_LARGE],
               status_seen[STATUS_EMPTY]);
      if (mismatch_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
